// ===== rtl/lrukv_pkg.sv =====
package lrukv_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int WORD_W      = 32;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_ENTRIES);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WORD_W-1:0] word_t;

	// Result of the parallel tag search and replacement pick for one request
	typedef struct packed {
		logic                   hit;
		idx_t                   hit_idx;
		idx_t                   hit_rank;
		idx_t                   victim_idx;
		idx_t                   fill_idx;
		logic [MAX_ENTRIES-1:0] match;
	} lookup_t;

endpackage

// ===== rtl/lrukv_lookup.sv =====
module lrukv_lookup import lrukv_pkg::*; (
	input  logic [MAX_ENTRIES-1:0] valid,
	input  word_t                  keys [MAX_ENTRIES],
	input  idx_t                   ranks [MAX_ENTRIES],
	input  cnt_t                   occ,
	input  logic                   evict,
	input  word_t                  key,
	output lookup_t                res
);

	cnt_t                   occ_m1;
	logic [MAX_ENTRIES-1:0] oldest;
	logic [MAX_ENTRIES-1:0] free_slots;

	assign occ_m1 = occ - CNT_W'(1);

	always_comb begin
		res = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			res.match[i] = valid[i] && (keys[i] == key);
			// ranks of valid entries are a permutation of 0..occ-1
			oldest[i]    = valid[i] && (ranks[i] == occ_m1[IDX_W-1:0]);
		end
		// walk down so the lowest index wins
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (res.match[i]) begin
				res.hit      = 1'b1;
				res.hit_idx  = IDX_W'(i);
				res.hit_rank = ranks[i];
			end
			if (oldest[i]) begin
				res.victim_idx = IDX_W'(i);
			end
		end
		free_slots = ~valid;
		if (evict) begin
			free_slots[res.victim_idx] = 1'b1;
		end
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (free_slots[i]) begin
				res.fill_idx = IDX_W'(i);
			end
		end
	end

endmodule

// ===== rtl/lru_key_value_cache_core.sv =====
// Channel   Direction  Accepted when              Payload
// s_*       in         s_tvalid && s_tready       tuser: command; tdata: lookup_key, write_value
// m_*       out        m_tvalid && m_tready       tuser: hit; tdata: read_value
// cfg_*     in         cfg_we                     cfg_wdata: capacity_in_use
//
// One request per cycle while no get waits: the request register feeds the tag search,
// LRU rank update and result register in the same cycle, so back-to-back requests see
// the state left by the one before. A get passes from the request register to the result register.
// A get waits in the request register only while the result register is full
// and m_tready is low; a put never waits. Reset clears all valid bits, ranks
// and the fill count at once; there is no clearing pass.
module lru_key_value_cache_core import lrukv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,   // [31:0] lookup_key, [63:32] write_value
	input  logic              s_tuser,   // [0] command
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // [31:0] read_value
	output logic              m_tuser,   // [0] hit
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata
);

	cnt_t                   cap_q;
	cnt_t                   cap_eff;

	logic                   valid_s1;
	logic                   cmd_s1;
	word_t                  key_s1;
	word_t                  wval_s1;

	logic [MAX_ENTRIES-1:0] valid_q, valid_d;
	word_t                  key_q   [MAX_ENTRIES];
	word_t                  value_q [MAX_ENTRIES];
	idx_t                   rank_q  [MAX_ENTRIES];
	idx_t                   rank_d  [MAX_ENTRIES];
	cnt_t                   occ_q, occ_d;

	logic                   out_valid_q;
	logic                   out_hit_q;
	word_t                  out_data_q;

	lookup_t                lk;
	logic                   evict;
	logic                   fire;
	logic                   do_insert;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_comb begin
		cap_eff = cap_q;
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_q > CNT_W'(MAX_ENTRIES)) begin
			cap_eff = CNT_W'(MAX_ENTRIES);
		end
	end

	// a put leaves no result, so it never waits on the output side
	assign fire     = valid_s1 && (cmd_s1 == CMD_PUT || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign evict    = occ_q >= cap_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			key_s1  <= s_tdata[31:0];
			wval_s1 <= s_tdata[63:32];
		end
	end

	lrukv_lookup u_lookup (
		.valid (valid_q),
		.keys  (key_q),
		.ranks (rank_q),
		.occ   (occ_q),
		.evict (evict),
		.key   (key_s1),
		.res   (lk)
	);

	assign do_insert = fire && cmd_s1 == CMD_PUT && !lk.hit;

	always_comb begin
		valid_d = valid_q;
		rank_d  = rank_q;
		occ_d   = occ_q;
		if (fire && lk.hit) begin
			// promote the hit entry, age the ones that were newer
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (valid_q[j] && rank_q[j] < lk.hit_rank) begin
					rank_d[j] = rank_q[j] + IDX_W'(1);
				end
			end
			rank_d[lk.hit_idx] = '0;
		end else if (do_insert) begin
			if (evict) begin
				valid_d[lk.victim_idx] = 1'b0;
			end
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (valid_d[j]) begin
					rank_d[j] = rank_q[j] + IDX_W'(1);
				end
			end
			valid_d[lk.fill_idx] = 1'b1;
			rank_d[lk.fill_idx]  = '0;
			if (!evict) begin
				occ_d = occ_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				rank_q[j] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			occ_q   <= occ_d;
			rank_q  <= rank_d;
		end
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			key_q[lk.fill_idx]   <= key_s1;
			value_q[lk.fill_idx] <= wval_s1;
		end else if (fire && cmd_s1 == CMD_PUT && lk.hit) begin
			value_q[lk.hit_idx] <= wval_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && cmd_s1 == CMD_GET) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && cmd_s1 == CMD_GET) begin
			out_hit_q  <= lk.hit;
			out_data_q <= lk.hit ? value_q[lk.hit_idx] : '1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_hit_q;

`ifndef NO_ASSERTIONS
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("fill count disagrees with valid bits");

	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(MAX_ENTRIES))
		else $error("fill count above table size");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lk.match))
		else $error("key present in more than one entry");

	a_get_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd_s1 == CMD_GET |=> m_tvalid)
		else $error("get request produced no result");

	a_insert_no_growth_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert && evict |=> occ_q == $past(occ_q))
		else $error("insert grew the table past capacity");
`endif

endmodule

// ===== verif/lru_key_value_cache_core_tb.sv =====
module lru_key_value_cache_core_tb;
	import lrukv_pkg::*;

	typedef struct packed {
		logic  hit;
		word_t value;
	} read_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [63:0]      s_tdata = '0;   // [31:0] lookup_key, [63:32] write_value
	logic             s_tuser = 1'b0; // [0] command
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [31:0]      m_tdata;        // [31:0] read_value
	logic             m_tuser;        // [0] hit
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	// Shadow copy of the cache
	logic         shadow_valid [MAX_ENTRIES];
	word_t        shadow_key   [MAX_ENTRIES];
	word_t        shadow_value [MAX_ENTRIES];
	int unsigned  shadow_rank  [MAX_ENTRIES];
	int unsigned  shadow_count;
	cnt_t         shadow_capacity;

	read_result_t pending_reads [$];
	read_result_t oldest_read;
	int           mismatches = 0;
	bit           idle_en = 1'b0;
	bit           stall_en = 1'b0;
	int           stall_left = 0;
	word_t        key_pool [24];

	lru_key_value_cache_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

	// Result-side backpressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			m_tready <= 1'b1;
		end else if (stall_en && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(1, 16);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reads.size() == 0) begin
				$display("%0t: read result with none pending: expected none, actual hit=%0b value=%h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				oldest_read = pending_reads.pop_front();
				if (m_tuser !== oldest_read.hit) begin
					$display("%0t: hit mismatch: expected %0b, actual %0b",
						$time, oldest_read.hit, m_tuser);
					mismatches++;
				end
				if (m_tdata !== oldest_read.value) begin
					$display("%0t: read_value mismatch: expected %h, actual %h",
						$time, oldest_read.value, m_tdata);
					mismatches++;
				end
			end
		end
	end

	function automatic void promote_entry(input int idx);
		int unsigned r;
		r = shadow_rank[idx];
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if (shadow_valid[j] && shadow_rank[j] < r) shadow_rank[j]++;
		end
		shadow_rank[idx] = 0;
	endfunction

	// Apply one request to the shadow cache; queue the read result of a get
	function automatic void apply_request(input logic cmd, input word_t key, input word_t val);
		int           slot;
		int           victim;
		int unsigned  worst;
		int unsigned  cap;
		read_result_t res;
		slot = -1;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (slot < 0 && shadow_valid[i] && shadow_key[i] == key) slot = i;
		end
		if (cmd == CMD_GET) begin
			if (slot >= 0) begin
				res.hit = 1'b1;
				res.value = shadow_value[slot];
				promote_entry(slot);
			end else begin
				res.hit = 1'b0;
				res.value = '1;
			end
			pending_reads.push_back(res);
		end else if (slot >= 0) begin
			shadow_value[slot] = val;
			promote_entry(slot);
		end else begin
			cap = (shadow_capacity == 0) ? 1 : shadow_capacity;
			if (cap > MAX_ENTRIES) cap = MAX_ENTRIES;
			if (shadow_count >= cap) begin
				victim = -1;
				worst = 0;
				for (int j = 0; j < MAX_ENTRIES; j++) begin
					if (shadow_valid[j] && (victim < 0 || shadow_rank[j] > worst)) begin
						victim = j;
						worst = shadow_rank[j];
					end
				end
				if (victim >= 0) begin
					shadow_valid[victim] = 1'b0;
					shadow_rank[victim] = 0;
					if (shadow_count > 0) shadow_count--;
				end
			end
			slot = -1;
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (!shadow_valid[j]) begin
					if (slot < 0) slot = j;
				end else begin
					shadow_rank[j]++;
				end
			end
			if (slot >= 0) begin
				shadow_valid[slot] = 1'b1;
				shadow_key[slot] = key;
				shadow_value[slot] = val;
				shadow_rank[slot] = 0;
				shadow_count++;
			end
		end
	endfunction

	task automatic send_request(input logic cmd, input word_t key, input word_t val);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {val, key};
		do @(posedge clk); while (!s_tready);
		apply_request(cmd, key, val);
	endtask

	// Hold off requests until every read result is back, then idle for extra_cycles
	task automatic drain_reads(input int extra_cycles);
		s_tvalid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (extra_cycles) @(posedge clk);
	endtask

	task automatic set_capacity(input cnt_t cap);
		drain_reads(4);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_capacity = cap;
	endtask

	task automatic test_field_extremes;
		send_request(CMD_GET, 32'h0000_0000, 32'h1234_5678);
		send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		// stored all-ones must come back as a hit, not a miss
		send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'h8000_0001, 32'h0000_0000);
		send_request(CMD_PUT, 32'h8000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
	endtask

	task automatic test_lru_replacement;
		// three entries held, capacity now two: a new key evicts only one
		set_capacity(5'd2);
		send_request(CMD_PUT, 32'h0000_0011, 32'hAAAA_0011);
		send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(CMD_PUT, 32'h0000_0012, 32'hAAAA_0012);
		send_request(CMD_GET, 32'h0000_0011, 32'h0000_0000);
		send_request(CMD_GET, 32'h0000_0012, 32'h0000_0000);
	endtask

	task automatic test_capacity_zero;
		set_capacity(5'd0);
		send_request(CMD_PUT, 32'h0000_0021, 32'h5555_5555);
		send_request(CMD_PUT, 32'h0000_0022, 32'hAAAA_AAAA);
		send_request(CMD_GET, 32'h0000_0021, 32'h0000_0000);
		send_request(CMD_GET, 32'h0000_0022, 32'h0000_0000);
	endtask

	task automatic test_random_traffic(input cnt_t cap, input int n_items, input bit pause_once);
		int    pool_size;
		int    pick;
		int    eff;
		word_t key;
		logic  cmd;
		set_capacity(cap);
		eff = (cap == 0) ? 1 : (cap > MAX_ENTRIES) ? MAX_ENTRIES : cap;
		pool_size = eff + $urandom_range(1, 8);
		for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
		if ($urandom_range(0, 1)) key_pool[0] = '1;
		else key_pool[0] = '0;
		for (int n = 0; n < n_items; n++) begin
			pick = $urandom_range(0, 19);
			if (pick < 17) begin
				key = key_pool[$urandom_range(0, pool_size - 1)];
			end else if (pick == 17) begin
				// near miss: one key bit flipped
				key = key_pool[$urandom_range(0, pool_size - 1)] ^ (32'd1 << $urandom_range(0, 31));
			end else begin
				key = $urandom;
			end
			cmd = ($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET;
			send_request(cmd, key, $urandom);
			if (pause_once && n == n_items / 2) drain_reads(1);
		end
	endtask

	initial begin
		cnt_t phase_caps [8];
		shadow_capacity = CAP_RESET;
		shadow_count = 0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_rank[i] = 0;
		end
		phase_caps = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd8, 5'd3, 5'd12};
		phase_caps[6] = cnt_t'($urandom_range(2, 15));
		phase_caps[7] = cnt_t'($urandom_range(0, 31));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_lru_replacement();
		test_capacity_zero();

		idle_en = 1'b1;
		stall_en = 1'b1;
		for (int p = 0; p < 8; p++) begin
			test_random_traffic(phase_caps[p], 95, p == 3);
		end
		idle_en = 1'b0;
		stall_en = 1'b0;
		test_random_traffic(5'd16, 60, 1'b0);

		drain_reads(8);
		if (mismatches == 0 && pending_reads.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lrukv_pkg.sv
rtl/lrukv_lookup.sv
rtl/lru_key_value_cache_core.sv
verif/lru_key_value_cache_core_tb.sv
